FILE: rtl/core/cks_pkg.sv
package cks_pkg;

    localparam int DataW = 16;
    localparam int AccW  = 17;
    localparam int ModeW = 3;
    localparam int IdxW  = 2;

    // Algorithm codes
    localparam logic [ModeW-1:0] MODE_FOLD   = 3'd0;
    localparam logic [ModeW-1:0] MODE_XOR    = 3'd1;
    localparam logic [ModeW-1:0] MODE_CMPL   = 3'd2;
    localparam logic [ModeW-1:0] MODE_BYTE   = 3'd3;
    localparam logic [ModeW-1:0] MODE_NEG    = 3'd4;
    localparam logic [ModeW-1:0] MODE_SUB    = 3'd5;
    localparam logic [ModeW-1:0] MODE_SHIFT  = 3'd6;
    localparam logic [ModeW-1:0] MODE_UNUSED = 3'd7;

    // Register indexes
    localparam logic [IdxW-1:0] REG_ALGORITHM = 2'd0;
    localparam logic [IdxW-1:0] REG_SEED      = 2'd1;

    localparam logic [DataW-1:0] ALL_ONES = 16'hFFFF;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [DataW-1:0] seed;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic [DataW-1:0] data;
        logic             last;
    } t_elem;

endpackage

FILE: rtl/core/cks_in_if.sv
interface cks_in_if;
    import cks_pkg::*;

    logic             valid;
    logic             ready;
    logic [DataW-1:0] data;
    logic             last;

    modport source (output valid, output data, output last, input ready);
    modport sink   (input valid, input data, input last, output ready);
endinterface

FILE: rtl/core/cks_out_if.sv
interface cks_out_if;
    import cks_pkg::*;

    logic             valid;
    logic             ready;
    logic [DataW-1:0] sum_result;
    logic [DataW-1:0] aux_result;

    modport source (output valid, output sum_result, output aux_result, input ready);
    modport sink   (input valid, input sum_result, input aux_result, output ready);
endinterface

FILE: rtl/core/cks_cfg.sv
module cks_cfg
    import cks_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IdxW-1:0]  i_cfg_idx,
    input  logic [DataW-1:0] i_cfg_wdata,
    output t_cfg             o_cfg
);

    logic [ModeW-1:0] r_algorithm;
    logic [DataW-1:0] r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_algorithm <= MODE_FOLD;
            r_seed      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ALGORITHM: r_algorithm <= i_cfg_wdata[ModeW-1:0];
                REG_SEED:      r_seed      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // unused code 7 runs as the fold sum
    always_comb begin
        o_cfg.mode = (r_algorithm == MODE_UNUSED) ? MODE_FOLD : r_algorithm;
        o_cfg.seed = r_seed;
    end

endmodule

FILE: rtl/core/cks_in_reg.sv
module cks_in_reg
    import cks_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    cks_in_if.sink i_in,
    input  logic  i_adv,
    output t_elem o_elem
);

    logic             r_valid;
    logic [DataW-1:0] r_data;
    logic             r_last;
    logic             w_take;

    assign i_in.ready = !r_valid || i_adv;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= i_in.data;
            r_last <= i_in.last;
        end
    end

    assign o_elem.valid = r_valid;
    assign o_elem.data  = r_data;
    assign o_elem.last  = r_last;

endmodule

FILE: rtl/core/cks_core.sv
module cks_core
    import cks_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_elem    i_elem,
    output logic     o_adv,
    cks_out_if.source o_out
);

    logic [AccW-1:0]  r_acc;
    logic [DataW-1:0] r_xacc;
    logic             r_started;
    logic             r_out_valid;
    logic [DataW-1:0] r_sum;
    logic [DataW-1:0] r_aux;

    logic [AccW-1:0]  n_acc;
    logic [DataW-1:0] n_xacc;
    logic [DataW-1:0] n_sum;
    logic [DataW-1:0] n_aux;

    logic             w_first;
    logic [AccW-1:0]  w_base;
    logic [DataW-1:0] w_base16;
    logic [DataW-1:0] w_xbase;
    logic [AccW-1:0]  w_fold;
    logic [AccW-1:0]  w_shl;
    logic [DataW-1:0] w_shf;
    logic [7:0]       w_byte;
    logic [7:0]       w_low;

    assign o_adv = i_elem.valid && (!r_out_valid || o_out.ready);

    always_comb begin
        w_first  = !r_started;
        w_base   = w_first ? {1'b0, i_cfg.seed} : r_acc;
        w_base16 = w_base[DataW-1:0];
        w_xbase  = w_first ? i_cfg.seed : r_xacc;
        w_byte   = i_elem.data[7:0];
        // end-around fold before the add
        w_fold   = (w_base > {1'b0, ALL_ONES}) ? (w_base - {1'b0, ALL_ONES}) : w_base;
        // shift-and-fold, skipped on the first element
        w_shl    = w_first ? {1'b0, w_base16} : {w_base16, 1'b0};
        w_shf    = (w_shl > {1'b0, ALL_ONES}) ? DataW'(w_shl - {1'b0, ALL_ONES})
                                              : w_shl[DataW-1:0];
        w_low    = w_shf[7:0] + w_byte;

        n_xacc = w_xbase;
        case (i_cfg.mode)
            MODE_FOLD:  n_acc = w_fold + {1'b0, i_elem.data};
            MODE_XOR: begin
                n_acc  = {1'b0, w_base16 + i_elem.data};
                n_xacc = w_xbase ^ i_elem.data;
            end
            MODE_CMPL:  n_acc = {1'b0, w_base16 + i_elem.data};
            MODE_BYTE,
            MODE_NEG:   n_acc = {1'b0, w_base16 + {8'd0, w_byte}};
            MODE_SUB:   n_acc = {1'b0, w_base16 - i_elem.data};
            MODE_SHIFT: n_acc = {1'b0, w_shf[15:8], w_low};
            default:    n_acc = w_fold + {1'b0, i_elem.data};
        endcase

        n_sum = n_acc[DataW-1:0];
        n_aux = '0;
        case (i_cfg.mode)
            MODE_XOR:  n_aux = n_xacc;
            MODE_CMPL: n_aux = ~n_acc[DataW-1:0];
            MODE_NEG:  n_sum = {8'd0, 8'd0 - n_acc[7:0]};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_xacc      <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_acc     <= n_acc;
                r_xacc    <= n_xacc;
                r_started <= !i_elem.last;
            end
            if (o_adv && i_elem.last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_elem.last) begin
            r_sum <= n_sum;
            r_aux <= n_aux;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sum_result = r_sum;
    assign o_out.aux_result = r_aux;

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_adv && i_elem.last |=> !r_started)
        else $error("region did not re-arm after last item");

    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_adv && !i_elem.last |=> r_started)
        else $error("region not marked open after non-last item");

    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_adv && i_elem.last))
        else $error("result appeared without a last item");

    a_no_adv_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !o_adv)
        else $error("item advanced over a held result");

endmodule

FILE: rtl/core/multi_mode_additive_checksum.sv
// Channel   Dir  Payload              Accepted when
// i_in      in   data[15:0], last     i_in.valid && i_in.ready
// o_out     out  sum_result, aux_res  o_out.valid && o_out.ready
// i_cfg_*   in   idx[1:0], wdata[15:0] i_cfg_we high
//
// One item per cycle sustained while no result waits on o_out. An item
// sits in the input register, then the accumulator update and result
// formation happen in one combinational pass into the accumulator and
// the result register, which raises o_out.valid for a last item.
// Synchronous active-low reset clears accumulators, region state and
// the result valid; registers reset to fold sum with a zero seed.
// A result waiting on o_out stalls only the input register; i_in.ready
// stays high while that register is empty.
module multi_mode_additive_checksum
    import cks_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    cks_in_if.sink           i_in,
    cks_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [IdxW-1:0]  i_cfg_idx,
    input  logic [DataW-1:0] i_cfg_wdata
);

    t_cfg  w_cfg;
    t_elem w_elem;
    logic  w_adv;

    // algorithm and seed registers
    cks_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // input register, refilled as its item advances
    cks_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (w_adv),
        .o_elem  (w_elem)
    );

    // accumulator update and result register
    cks_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_elem  (w_elem),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    import cks_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Indexes past the end of the register map; the block must drop these writes.
    localparam logic [IdxW-1:0] REG_SPARE_A = 2'd2;
    localparam logic [IdxW-1:0] REG_SPARE_B = 2'd3;

    // A result passes the input and result registers; give it some margin.
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [DataW-1:0] data;
        logic             last;
    } t_word;

    typedef struct packed {
        logic [DataW-1:0] sum;
        logic [DataW-1:0] aux;
    } t_sums;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IdxW-1:0]  cfg_idx;
    logic [DataW-1:0] cfg_wdata;

    cks_in_if  in_ch ();
    cks_out_if out_ch ();

    multi_mode_additive_checksum u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Items waiting for the driver, and checksums still owed by the block.
    t_word words_to_send[$];
    t_sums sums_due[$];
    t_word next_word;

    int words_pushed;
    int words_taken;
    int err_count;

    // Idle odds in percent, changed per phase by the stimulus.
    int send_idle_pct;
    int recv_idle_pct;

    // Our copy of the block's registers and running state.
    logic [ModeW-1:0] model_mode;
    logic [DataW-1:0] model_seed;
    logic [AccW-1:0]  acc;
    logic [DataW-1:0] xacc;
    logic             region_open;

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    // Fold one accepted item into the running checksum; on the last item of
    // a region, queue the checksum the block owes and re-arm.
    function automatic void fold_word_into_sum(input logic [DataW-1:0] word,
                                               input logic last_flag);
        logic [ModeW-1:0] m;
        logic             first;
        t_sums            res;
        m = (model_mode == MODE_UNUSED) ? MODE_FOLD : model_mode;
        first = !region_open;
        if (first) begin
            acc  = {1'b0, model_seed};
            xacc = model_seed;
        end
        region_open = 1'b1;
        case (m)
            MODE_FOLD: begin
                // end-around fold happens before the add, never after
                if (acc > {1'b0, ALL_ONES}) begin
                    acc = acc - {1'b0, ALL_ONES};
                end
                acc = acc + {1'b0, word};
            end
            MODE_XOR: begin
                acc  = {1'b0, acc[DataW-1:0] + word};
                xacc = xacc ^ word;
            end
            MODE_CMPL: begin
                acc = {1'b0, acc[DataW-1:0] + word};
            end
            MODE_BYTE, MODE_NEG: begin
                acc = {1'b0, acc[DataW-1:0] + {8'h00, word[7:0]}};
            end
            MODE_SUB: begin
                acc = {1'b0, acc[DataW-1:0] - word};
            end
            MODE_SHIFT: begin
                acc[AccW-1] = 1'b0;
                if (!first) begin
                    acc = acc << 1;
                    if (acc > {1'b0, ALL_ONES}) begin
                        acc = acc - {1'b0, ALL_ONES};
                    end
                end
                // byte goes into the low half only, carry is dropped
                acc[7:0] = acc[7:0] + word[7:0];
            end
            default: ;
        endcase
        if (last_flag) begin
            res.sum = acc[DataW-1:0];
            res.aux = '0;
            if (m == MODE_XOR) begin
                res.aux = xacc;
            end else if (m == MODE_CMPL) begin
                res.aux = ALL_ONES - res.sum;
            end else if (m == MODE_NEG) begin
                res.sum = {8'h00, 8'h00 - res.sum[7:0]};
            end
            sums_due.push_back(res);
            region_open = 1'b0;
        end
    endfunction

    // Driver: keeps the current item on the bus until the block takes it.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            in_ch.last  <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                fold_word_into_sum(in_ch.data, in_ch.last);
                words_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = words_to_send.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= next_word.data;
                    in_ch.last  <= next_word.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: each checksum taken must match the oldest one owed.
    always @(posedge clk) begin
        t_sums want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (sums_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result sum %h aux %h",
                                              out_ch.sum_result, out_ch.aux_result));
                end else begin
                    want = sums_due.pop_front();
                    if (out_ch.sum_result !== want.sum) begin
                        report_mismatch($sformatf("sum_result got %h want %h",
                                                  out_ch.sum_result, want.sum));
                    end
                    if (out_ch.aux_result !== want.aux) begin
                        report_mismatch($sformatf("aux_result got %h want %h",
                                                  out_ch.aux_result, want.aux));
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_word(input logic [DataW-1:0] data, input logic last_flag);
        t_word w;
        w.data = data;
        w.last = last_flag;
        words_to_send.push_back(w);
        words_pushed++;
    endtask

    // Mostly random words, with the all-zero and all-one extremes mixed in.
    function automatic logic [DataW-1:0] rand_word();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return ALL_ONES;
        end
        return DataW'($urandom);
    endfunction

    task automatic push_region(input int len, input bit close);
        for (int i = 0; i < len; i++) begin
            push_word(rand_word(), close && (i == len - 1));
        end
    endtask

    // Register write; the block is idle whenever this is called, so the
    // model copy can follow at once.
    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ALGORITHM) begin
            model_mode = value[ModeW-1:0];
        end else if (idx == REG_SEED) begin
            model_seed = value;
        end
    endtask

    // Hold here until every pushed item is taken and every checksum is in,
    // then let a non-last item still in the pipe settle.
    task automatic wait_idle();
        @(posedge clk);
        while (words_taken != words_pushed || sums_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        logic [ModeW-1:0] mode_pick;
        int               len;
        int               phase_words;

        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_wdata     = '0;
        words_pushed  = 0;
        words_taken   = 0;
        err_count     = 0;
        model_mode    = MODE_FOLD;
        model_seed    = '0;
        acc           = '0;
        xacc          = '0;
        region_open   = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 58;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // ---- Directed part ----
        // Fold sum from reset registers: the accumulator runs past 16 bits
        // and the fold kicks in before the final add.
        push_word(16'hFFFF, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'hFFFF, 1'b1);
        wait_idle();

        // Sum plus xor from a nonzero seed.
        write_reg(REG_ALGORITHM, DataW'(MODE_XOR));
        write_reg(REG_SEED, 16'h5A5A);
        push_word(16'h1234, 1'b0);
        push_word(16'hFFFF, 1'b1);
        wait_idle();

        // Complement mode, sum wraps to zero.
        write_reg(REG_ALGORITHM, DataW'(MODE_CMPL));
        write_reg(REG_SEED, 16'hFFFF);
        push_word(16'h0001, 1'b1);
        wait_idle();

        // Byte sum: upper byte of data must be ignored.
        write_reg(REG_ALGORITHM, DataW'(MODE_BYTE));
        write_reg(REG_SEED, 16'h0000);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h00FF, 1'b0);
        push_word(16'hABFF, 1'b1);
        wait_idle();

        // Negated byte: zero stays zero, one becomes 0xFF.
        write_reg(REG_ALGORITHM, DataW'(MODE_NEG));
        push_word(16'h0000, 1'b1);
        push_word(16'h0001, 1'b1);
        wait_idle();

        // Seed minus sum, wraps below zero.
        write_reg(REG_ALGORITHM, DataW'(MODE_SUB));
        push_word(16'hFFFF, 1'b1);
        wait_idle();

        // Shift fold: first element is not shifted, later ones fold.
        write_reg(REG_ALGORITHM, DataW'(MODE_SHIFT));
        write_reg(REG_SEED, 16'hFFFF);
        push_word(16'h00FF, 1'b0);
        push_word(16'h00FF, 1'b0);
        push_word(16'h00FF, 1'b1);
        // Leave a region open, then change both registers under it: the new
        // rule applies to the live accumulator, the new seed waits.
        push_word(16'h0080, 1'b0);
        wait_idle();
        write_reg(REG_ALGORITHM, DataW'(MODE_FOLD));
        write_reg(REG_SEED, 16'h1234);
        push_word(16'hFFFF, 1'b1);
        wait_idle();

        // Unused code behaves as fold sum.
        write_reg(REG_ALGORITHM, DataW'(MODE_UNUSED));
        write_reg(REG_SEED, 16'h0001);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0001, 1'b1);
        wait_idle();

        // Writes past the register map change nothing.
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'hFFFF);
        push_word(16'h0007, 1'b1);
        wait_idle();

        // ---- Random part: 12 phases of at least 75 items ----
        // Phases 0-3 sender idles less than receiver, 4-7 the reverse,
        // 8-11 no idling at all.
        for (int p = 0; p < 12; p++) begin
            if (p < 4) begin
                send_idle_pct = 27;
                recv_idle_pct = 58;
            end else if (p < 8) begin
                send_idle_pct = 58;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // First eight phases walk every algorithm code, then random.
            // Upper data bits of the algorithm write are junk on purpose.
            mode_pick = (p < 8) ? ModeW'(p) : ModeW'($urandom_range(7));
            write_reg(REG_ALGORITHM, {13'($urandom), mode_pick});
            if (p == 0) begin
                write_reg(REG_SEED, 16'h0000);
            end else if (p == 1) begin
                write_reg(REG_SEED, ALL_ONES);
            end else if ($urandom_range(3) != 0) begin
                write_reg(REG_SEED, DataW'($urandom));
            end
            if ($urandom_range(2) == 0) begin
                write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, DataW'($urandom));
            end

            phase_words = 0;
            while (phase_words < 75) begin
                // Mostly short regions; now and then a long one to push
                // the fold and shift paths through many carries.
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(1, 6);
                push_region(len, 1'b1);
                phase_words += len;
                // In phase 5 the sender stalls mid-phase until every checksum is back.
                if (p == 5 && phase_words >= 35 && phase_words - len < 35) begin
                    wait_idle();
                end
            end
            // Sometimes leave a region open across the next register writes.
            if ($urandom_range(3) == 0) begin
                push_region($urandom_range(1, 3), 1'b0);
            end
            wait_idle();
        end

        // Catch any stray result after the last expected one.
        repeat (8) @(posedge clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
